// File: hw/rtl/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

    // configuration port geometry
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_C1 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_C2 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_C3 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_C4 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_C5 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_C6 = 3'd5;

    // compensation constants
    localparam logic signed [18:0] TEMP_NOMINAL  = 19'sd2000;
    localparam logic signed [19:0] TEMP_LOW_SPAN = 20'sd3500;

    // calibration words as seen by the datapath
    typedef struct packed {
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] c4;
        logic [15:0] c5;
        logic [15:0] c6;
    } bpc_cal_t;

endpackage

`default_nettype wire

// File: hw/rtl/bpc_regs.sv
`default_nettype none

module bpc_regs
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bpc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [bpc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [bpc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output bpc_pkg::bpc_cal_t                    cal
);

    import bpc_pkg::*;

    bpc_cal_t               cal_reg;
    bpc_cal_t               cal_next;
    logic [REG_IDX_W-1:0]   idx;
    logic                   wr_en;
    logic [15:0]            rd_word;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cal    = cal_reg;

    // register write decode, unknown indexes are dropped
    always_comb
    begin
        cal_next = cal_reg;
        if (wr_en)
        begin
            case (idx)
                REG_C1:  cal_next.c1 = pwdata[15:0];
                REG_C2:  cal_next.c2 = pwdata[15:0];
                REG_C3:  cal_next.c3 = pwdata[15:0];
                REG_C4:  cal_next.c4 = pwdata[15:0];
                REG_C5:  cal_next.c5 = pwdata[15:0];
                REG_C6:  cal_next.c6 = pwdata[15:0];
                default: cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_C1:  rd_word = cal_reg.c1;
            REG_C2:  rd_word = cal_reg.c2;
            REG_C3:  rd_word = cal_reg.c3;
            REG_C4:  rd_word = cal_reg.c4;
            REG_C5:  rd_word = cal_reg.c5;
            REG_C6:  rd_word = cal_reg.c6;
            default: rd_word = 16'd0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-16){1'b0}}, rd_word};

endmodule

`default_nettype wire

// File: hw/rtl/barometric_pressure_compensation.sv
`default_nettype none

// Second-order barometer compensation. Each item carries a raw 24-bit pressure
// and temperature conversion and yields one compensated pressure (0.01 mbar,
// clamped at zero, saturated at 1048575) and temperature (0.01 C). The datapath
// is a nine-stage pipeline that can take a new item every cycle unless a stall
// on the output has backed up to its first stage. Each stage has its own valid
// bit and ready is chained back stage by stage, so bubbles close up and the
// block keeps taking items while a finished result waits on the output. The six
// calibration words are APB registers at byte addresses 0x00..0x14 and are
// meant to be written while no item is in flight.

module barometric_pressure_compensation
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bpc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [bpc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [bpc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    // input items
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [47:0]                     s_axis_tdata,  // raw_pressure[23:0], raw_temperature[47:24]
    // result items
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [39:0]                     m_axis_tdata   // pressure[19:0], temperature[38:20], zero[39]
);

    import bpc_pkg::*;

    localparam int NS = 9;

    bpc_cal_t cal;

    bpc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS:0]   rdy;

    // a stage can load when it is empty or its contents move on
    always_comb
    begin
        rdy[NS] = m_axis_tready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (rdy[i])
            begin
                vld_next[i] = (i == 0) ? s_axis_tvalid : vld_reg[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = vld_reg[NS-1];

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    // stage 0
    logic        [23:0] s0_d1_reg;
    logic signed [24:0] s0_dt_reg,  s0_dt_next;
    // stage 1
    logic        [23:0] s1_d1_reg;
    logic signed [41:0] s1_p6_reg,  s1_p6_next;
    logic signed [41:0] s1_p4_reg,  s1_p4_next;
    logic signed [41:0] s1_p3_reg,  s1_p3_next;
    logic signed [49:0] s1_pdd_reg, s1_pdd_next;
    // stage 2
    logic        [23:0] s2_d1_reg;
    logic signed [18:0] s2_q_reg,     s2_q_next;
    logic signed [19:0] s2_vl_reg,    s2_vl_next;
    logic signed [18:0] s2_temp_reg,  s2_temp_next;
    logic signed [39:0] s2_off_reg,   s2_off_next;
    logic signed [39:0] s2_sens_reg,  s2_sens_next;
    logic        [16:0] s2_t2_reg;
    logic               s2_low_reg,   s2_vlow_reg;
    // stage 3
    logic        [23:0] s3_d1_reg;
    logic        [35:0] s3_lo2_reg,   s3_lo2_next;
    logic        [35:0] s3_vl2_reg,   s3_vl2_next;
    logic signed [18:0] s3_temp_reg;
    logic signed [39:0] s3_off_reg,   s3_sens_reg;
    logic        [16:0] s3_t2_reg;
    logic               s3_low_reg,   s3_vlow_reg;
    // stage 4
    logic        [23:0] s4_d1_reg;
    logic        [39:0] s4_off2_reg,  s4_off2_next;
    logic        [39:0] s4_sens2_reg, s4_sens2_next;
    logic signed [18:0] s4_temp_reg;
    logic signed [39:0] s4_off_reg,   s4_sens_reg;
    logic        [16:0] s4_t2_reg;
    logic               s4_low_reg;
    // stage 5
    logic        [23:0] s5_d1_reg;
    logic signed [18:0] s5_temp_reg,  s5_temp_next;
    logic signed [39:0] s5_off_reg,   s5_off_next;
    logic signed [39:0] s5_sens_reg,  s5_sens_next;
    // stage 6
    logic        [43:0] s6_plo_reg,   s6_plo_next;
    logic signed [44:0] s6_phi_reg,   s6_phi_next;
    logic signed [39:0] s6_off_reg;
    logic signed [18:0] s6_temp_reg;
    // stage 7
    logic signed [43:0] s7_x_reg,     s7_x_next;
    logic signed [39:0] s7_off_reg;
    logic signed [18:0] s7_temp_reg;
    // stage 8
    logic        [19:0] s8_pres_reg,  s8_pres_next;
    logic signed [18:0] s8_temp_reg;

    // ------------------------------------------------------------------
    // stage logic
    // ------------------------------------------------------------------
    logic signed [41:0] q_full, o_full, s_full;
    logic signed [34:0] o_div;
    logic signed [33:0] s_div;
    logic signed [37:0] lo2_full;
    logic signed [39:0] vl2_full;
    logic        [39:0] lo2_x5, vl2_x7, vl2_x11;
    logic signed [64:0] prod, prod_adj;
    logic signed [44:0] num;

    // dt = d2 - c5 * 2^8
    assign s0_dt_next = $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, cal.c5, 8'd0});

    // first products of dt
    assign s1_p6_next  = s0_dt_reg * $signed({1'b0, cal.c6});
    assign s1_p4_next  = s0_dt_reg * $signed({1'b0, cal.c4});
    assign s1_p3_next  = s0_dt_reg * $signed({1'b0, cal.c3});
    assign s1_pdd_next = s0_dt_reg * s0_dt_reg;

    // truncating shifts toward zero and first-order terms
    always_comb
    begin
        q_full = s1_p6_reg + (s1_p6_reg[41] ? 42'sd8388607 : 42'sd0);
        o_full = s1_p4_reg + (s1_p4_reg[41] ? 42'sd127 : 42'sd0);
        s_full = s1_p3_reg + (s1_p3_reg[41] ? 42'sd255 : 42'sd0);
        o_div  = o_full[41:7];
        s_div  = s_full[41:8];
        s2_q_next    = q_full[41:23];
        s2_vl_next   = {s2_q_next[18], s2_q_next} + TEMP_LOW_SPAN;
        s2_temp_next = s2_q_next + TEMP_NOMINAL;
        s2_off_next  = $signed({8'd0, cal.c2, 16'd0}) + {{5{o_div[34]}}, o_div};
        s2_sens_next = $signed({9'd0, cal.c1, 15'd0}) + {{6{s_div[33]}}, s_div};
    end

    // squares for the low-temperature terms
    always_comb
    begin
        lo2_full    = s2_q_reg * s2_q_reg;
        vl2_full    = s2_vl_reg * s2_vl_reg;
        s3_lo2_next = lo2_full[35:0];
        s3_vl2_next = vl2_full[35:0];
    end

    // off2 and sens2 from shift-add multiples
    always_comb
    begin
        lo2_x5  = {2'd0, s3_lo2_reg, 2'd0} + {4'd0, s3_lo2_reg};
        vl2_x7  = {1'b0, s3_vl2_reg, 3'd0} - {4'd0, s3_vl2_reg};
        vl2_x11 = {1'b0, s3_vl2_reg, 3'd0} + {3'd0, s3_vl2_reg, 1'b0} + {4'd0, s3_vl2_reg};
        s4_off2_next  = {1'b0, lo2_x5[39:1]} + (s3_vlow_reg ? vl2_x7 : 40'd0);
        s4_sens2_next = {2'd0, lo2_x5[39:2]} + (s3_vlow_reg ? {1'b0, vl2_x11[39:1]} : 40'd0);
    end

    // apply the second-order correction below nominal temperature
    always_comb
    begin
        s5_temp_next = s4_temp_reg - (s4_low_reg ? $signed({2'd0, s4_t2_reg}) : 19'sd0);
        s5_off_next  = s4_off_reg  - (s4_low_reg ? $signed(s4_off2_reg)  : 40'sd0);
        s5_sens_next = s4_sens_reg - (s4_low_reg ? $signed(s4_sens2_reg) : 40'sd0);
    end

    // d1 * sens split into two partial products
    assign s6_plo_next = s5_d1_reg * s5_sens_reg[19:0];
    assign s6_phi_next = $signed({1'b0, s5_d1_reg}) * $signed(s5_sens_reg[39:20]);

    // combine and divide by 2^21 toward zero
    always_comb
    begin
        prod      = $signed({s6_phi_reg, 20'd0}) + $signed({21'd0, s6_plo_reg});
        prod_adj  = prod + (prod[64] ? 65'sd2097151 : 65'sd0);
        s7_x_next = prod_adj[64:21];
    end

    // subtract offset, divide by 2^15, clamp and saturate
    always_comb
    begin
        num = {s7_x_reg[43], s7_x_reg} - {{5{s7_off_reg[39]}}, s7_off_reg};
        if (num[44])
        begin
            s8_pres_next = 20'd0;
        end
        else if (|num[43:35])
        begin
            s8_pres_next = 20'hFFFFF;
        end
        else
        begin
            s8_pres_next = num[34:15];
        end
    end

    // payload registers, loaded when their stage accepts
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s0_d1_reg <= s_axis_tdata[23:0];
            s0_dt_reg <= s0_dt_next;
        end
        if (rdy[1])
        begin
            s1_d1_reg  <= s0_d1_reg;
            s1_p6_reg  <= s1_p6_next;
            s1_p4_reg  <= s1_p4_next;
            s1_p3_reg  <= s1_p3_next;
            s1_pdd_reg <= s1_pdd_next;
        end
        if (rdy[2])
        begin
            s2_d1_reg   <= s1_d1_reg;
            s2_q_reg    <= s2_q_next;
            s2_vl_reg   <= s2_vl_next;
            s2_temp_reg <= s2_temp_next;
            s2_off_reg  <= s2_off_next;
            s2_sens_reg <= s2_sens_next;
            s2_t2_reg   <= s1_pdd_reg[47:31];
            s2_low_reg  <= s2_q_next[18];
            s2_vlow_reg <= s2_vl_next[19];
        end
        if (rdy[3])
        begin
            s3_d1_reg   <= s2_d1_reg;
            s3_lo2_reg  <= s3_lo2_next;
            s3_vl2_reg  <= s3_vl2_next;
            s3_temp_reg <= s2_temp_reg;
            s3_off_reg  <= s2_off_reg;
            s3_sens_reg <= s2_sens_reg;
            s3_t2_reg   <= s2_t2_reg;
            s3_low_reg  <= s2_low_reg;
            s3_vlow_reg <= s2_vlow_reg;
        end
        if (rdy[4])
        begin
            s4_d1_reg    <= s3_d1_reg;
            s4_off2_reg  <= s4_off2_next;
            s4_sens2_reg <= s4_sens2_next;
            s4_temp_reg  <= s3_temp_reg;
            s4_off_reg   <= s3_off_reg;
            s4_sens_reg  <= s3_sens_reg;
            s4_t2_reg    <= s3_t2_reg;
            s4_low_reg   <= s3_low_reg;
        end
        if (rdy[5])
        begin
            s5_d1_reg   <= s4_d1_reg;
            s5_temp_reg <= s5_temp_next;
            s5_off_reg  <= s5_off_next;
            s5_sens_reg <= s5_sens_next;
        end
        if (rdy[6])
        begin
            s6_plo_reg  <= s6_plo_next;
            s6_phi_reg  <= s6_phi_next;
            s6_off_reg  <= s5_off_reg;
            s6_temp_reg <= s5_temp_reg;
        end
        if (rdy[7])
        begin
            s7_x_reg    <= s7_x_next;
            s7_off_reg  <= s6_off_reg;
            s7_temp_reg <= s6_temp_reg;
        end
        if (rdy[8])
        begin
            s8_pres_reg <= s8_pres_next;
            s8_temp_reg <= s7_temp_reg;
        end
    end

    assign m_axis_tdata = {1'b0, s8_temp_reg, s8_pres_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // very cold implies cold
    a_vlow_implies_low: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && s3_vlow_reg |-> s3_low_reg)
        else $error("very-low flag set without low flag");

    // when very cold the nominal distance exceeds the very-low distance
    a_square_order: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && s3_vlow_reg |-> (s3_lo2_reg > s3_vl2_reg))
        else $error("low-temperature squares out of order");

    // an empty pipeline always takes an item
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg == '0 |-> s_axis_tready)
        else $error("empty pipeline not ready");

    // an accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted item lost at entry");

endmodule

`default_nettype wire
